/* src/rcrp_pkg.sv */
package rcrp_pkg;

  localparam int OFS_W = 18;

  localparam logic [7:0] KIND_SR    = 8'd200;
  localparam logic [7:0] KIND_RR    = 8'd201;
  localparam logic [7:0] KIND_SDES  = 8'd202;
  localparam logic [7:0] KIND_BYE   = 8'd203;
  localparam logic [7:0] KIND_APP   = 8'd204;
  localparam logic [7:0] ITEM_CNAME = 8'd1;

  localparam logic [OFS_W-1:0] OFS_COUNT     = 18'd0;
  localparam logic [OFS_W-1:0] OFS_KIND      = 18'd1;
  localparam logic [OFS_W-1:0] OFS_LEN_END   = 18'd3;
  localparam logic [OFS_W-1:0] SR_PKT_END    = 18'd23;
  localparam logic [OFS_W-1:0] SR_OCT_END    = 18'd27;
  localparam logic [OFS_W-1:0] SR_BLOCK_OFS  = 18'd32;
  localparam logic [OFS_W-1:0] RR_BLOCK_OFS  = 18'd12;
  localparam logic [OFS_W-1:0] SDES_SSRC_END = 18'd7;
  localparam logic [OFS_W-1:0] SDES_ITEM_OFS = 18'd8;

  localparam logic [OFS_W-1:0] BLK_FRAC = 18'd0;
  localparam logic [OFS_W-1:0] BLK_LOST = 18'd3;
  localparam logic [OFS_W-1:0] BLK_HSEQ = 18'd7;
  localparam logic [OFS_W-1:0] BLK_JIT  = 18'd11;
  localparam logic [OFS_W-1:0] BLK_LSR  = 18'd15;
  localparam logic [OFS_W-1:0] BLK_DLSR = 18'd19;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SR_CNT,
    OP_RR_CNT,
    OP_UNKNOWN,
    OP_SR_PKT,
    OP_SR_OCT,
    OP_FRAC,
    OP_LOST,
    OP_HSEQ,
    OP_JIT,
    OP_LSR,
    OP_DLSR,
    OP_SSRC_HOLD,
    OP_CNAME
  } op_t;

  typedef struct packed {
    logic        last;
    op_t         op;
    logic [31:0] word;
  } item_t;

endpackage

/* src/rtcp_compound_report_parser_unit.sv */
// Compound RTCP report parser.
// Input channel: one datagram byte per transfer on in_data_byte, with
// in_end_of_datagram marking the final byte. A transfer happens when
// in_valid is high and in_stall is low.
// Output channel: one statistics snapshot per datagram, presented on the
// out_* fields with out_valid; it is taken when out_stall is low.
// Throughput: one byte per cycle while in_stall is low. The front parser
// tracks the packet offset and classifies each byte in the cycle it is taken;
// the back end applies the resulting update when it pops the item from a
// QUEUE_DEPTH-entry queue. The final byte's item is registered in the queue,
// then loaded into the snapshot registers, behind any earlier queued bytes.
// While the receiver stalls, the snapshot holds and later bytes keep flowing
// until the queue holds a final byte that cannot be emitted; in_stall rises
// only when the queue is full.
// Reset (rst_n low, synchronous) empties the queue, clears all statistics and
// parser state, and drops any snapshot not yet taken.
module rtcp_compound_report_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_datagram,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sender_reports_seen,
  output logic [31:0] out_receiver_reports_seen,
  output logic [31:0] out_sender_packet_total,
  output logic [31:0] out_sender_octet_total,
  output logic [7:0]  out_loss_fraction,
  output logic [23:0] out_lost_total,
  output logic [31:0] out_highest_sequence,
  output logic [31:0] out_arrival_jitter,
  output logic [31:0] out_last_sr_stamp,
  output logic [31:0] out_delay_since_sr,
  output logic [31:0] out_peer_ssrc,
  output logic        out_unknown_type_seen
);
  import rcrp_pkg::*;

  logic  accept;
  item_t fe_item;
  logic  q_full;
  logic  q_pop_valid;
  item_t q_pop_item;
  logic  q_pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  rcrp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .in_data_byte       (in_data_byte),
    .in_end_of_datagram (in_end_of_datagram),
    .item               (fe_item)
  );

  rcrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (fe_item),
    .full      (q_full),
    .pop_valid (q_pop_valid),
    .pop_item  (q_pop_item),
    .pop       (q_pop)
  );

  rcrp_back u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .pop_valid                 (q_pop_valid),
    .pop_item                  (q_pop_item),
    .pop                       (q_pop),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_sender_reports_seen   (out_sender_reports_seen),
    .out_receiver_reports_seen (out_receiver_reports_seen),
    .out_sender_packet_total   (out_sender_packet_total),
    .out_sender_octet_total    (out_sender_octet_total),
    .out_loss_fraction         (out_loss_fraction),
    .out_lost_total            (out_lost_total),
    .out_highest_sequence      (out_highest_sequence),
    .out_arrival_jitter        (out_arrival_jitter),
    .out_last_sr_stamp         (out_last_sr_stamp),
    .out_delay_since_sr        (out_delay_since_sr),
    .out_peer_ssrc             (out_peer_ssrc),
    .out_unknown_type_seen     (out_unknown_type_seen)
  );

  a_snapshot_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop && q_pop_item.last))
    else $error("snapshot raised without a final byte");

  a_hold_last_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && q_pop_valid && q_pop_item.last) |-> !q_pop)
    else $error("final byte taken while snapshot is stalled");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_pop_valid)
    else $error("input stalled with an empty queue");

endmodule

/* src/rcrp_front.sv */
module rcrp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     in_data_byte,
  input  logic           in_end_of_datagram,
  output rcrp_pkg::item_t item
);
  import rcrp_pkg::*;

  logic [OFS_W-1:0] off_r, off_nxt;
  logic [OFS_W-1:0] len_r, len_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [4:0]       bc_r, bc_nxt;
  logic [31:0]      wg_r, wg_nxt;
  logic             stop_r, stop_nxt;
  logic [31:0]      wgn;
  logic             adv;
  op_t              op;

  function automatic op_t block_op(input logic [OFS_W-1:0] ofs,
                                   input logic [OFS_W-1:0] base,
                                   input logic [4:0] bc);
    logic [OFS_W-1:0] rel;
    op_t              res;
    rel = ofs - base;
    res = OP_NONE;
    if (bc != 5'd0 && ofs >= base) begin
      unique case (rel)
        BLK_FRAC: res = OP_FRAC;
        BLK_LOST: res = OP_LOST;
        BLK_HSEQ: res = OP_HSEQ;
        BLK_JIT:  res = OP_JIT;
        BLK_LSR:  res = OP_LSR;
        BLK_DLSR: res = OP_DLSR;
        default:  res = OP_NONE;
      endcase
    end
    return res;
  endfunction

  assign wgn = {wg_r[23:0], in_data_byte};

  always_comb begin
    off_nxt  = off_r;
    len_nxt  = len_r;
    kind_nxt = kind_r;
    bc_nxt   = bc_r;
    wg_nxt   = wg_r;
    stop_nxt = stop_r;
    adv      = 1'b0;
    op       = OP_NONE;
    if (!stop_r) begin
      wg_nxt = wgn;
      adv    = 1'b1;
      if (off_r == OFS_COUNT) begin
        bc_nxt = in_data_byte[4:0];
      end else if (off_r == OFS_KIND) begin
        kind_nxt = in_data_byte;
        priority if (in_data_byte == KIND_SR) begin
          op = OP_SR_CNT;
        end else if (in_data_byte == KIND_RR) begin
          op = OP_RR_CNT;
        end else if (in_data_byte != KIND_SDES && in_data_byte != KIND_BYE &&
                     in_data_byte != KIND_APP) begin
          op       = OP_UNKNOWN;
          stop_nxt = 1'b1;
          adv      = 1'b0;
        end else begin
          op = OP_NONE;
        end
      end else if (off_r == OFS_LEN_END) begin
        len_nxt = {wgn[15:0], 2'b11};
      end else if (off_r > OFS_LEN_END) begin
        if (kind_r == KIND_SR) begin
          if (off_r == SR_PKT_END) begin
            op = OP_SR_PKT;
          end else if (off_r == SR_OCT_END) begin
            op = OP_SR_OCT;
          end else begin
            op = block_op(off_r, SR_BLOCK_OFS, bc_r);
          end
        end else if (kind_r == KIND_RR) begin
          op = block_op(off_r, RR_BLOCK_OFS, bc_r);
        end else if (kind_r == KIND_SDES) begin
          if (off_r == SDES_SSRC_END) begin
            op = OP_SSRC_HOLD;
          end else if (off_r == SDES_ITEM_OFS && in_data_byte == ITEM_CNAME) begin
            op = OP_CNAME;
          end
        end
      end
      if (adv) begin
        if (off_r >= OFS_LEN_END && off_r >= len_nxt) begin
          off_nxt = '0;
        end else begin
          off_nxt = off_r + 1'b1;
        end
      end
    end
  end

  assign item.last = in_end_of_datagram;
  assign item.op   = op;
  assign item.word = wgn;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_end_of_datagram)) begin
      off_r  <= '0;
      len_r  <= '0;
      kind_r <= '0;
      bc_r   <= '0;
      wg_r   <= '0;
      stop_r <= 1'b0;
    end else if (accept) begin
      off_r  <= off_nxt;
      len_r  <= len_nxt;
      kind_r <= kind_nxt;
      bc_r   <= bc_nxt;
      wg_r   <= wg_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

/* src/rcrp_queue.sv */
module rcrp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rcrp_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  output rcrp_pkg::item_t pop_item,
  input  logic            pop
);
  import rcrp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = CW'(count_r + CW'(push) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/rcrp_back.sv */
module rcrp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  input  rcrp_pkg::item_t pop_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_sender_reports_seen,
  output logic [31:0]     out_receiver_reports_seen,
  output logic [31:0]     out_sender_packet_total,
  output logic [31:0]     out_sender_octet_total,
  output logic [7:0]      out_loss_fraction,
  output logic [23:0]     out_lost_total,
  output logic [31:0]     out_highest_sequence,
  output logic [31:0]     out_arrival_jitter,
  output logic [31:0]     out_last_sr_stamp,
  output logic [31:0]     out_delay_since_sr,
  output logic [31:0]     out_peer_ssrc,
  output logic            out_unknown_type_seen
);
  import rcrp_pkg::*;

  logic [31:0] sr_r, sr_nxt;
  logic [31:0] rr_r, rr_nxt;
  logic [31:0] pkt_r, pkt_nxt;
  logic [31:0] oct_r, oct_nxt;
  logic [7:0]  frac_r, frac_nxt;
  logic [23:0] lost_r, lost_nxt;
  logic [31:0] hseq_r, hseq_nxt;
  logic [31:0] jit_r, jit_nxt;
  logic [31:0] lsr_r, lsr_nxt;
  logic [31:0] dlsr_r, dlsr_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic [31:0] peer_r, peer_nxt;
  logic        unk_r, unk_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        load;

  assign pop  = pop_valid && (!pop_item.last || !out_valid_r || !out_stall);
  assign load = pop && pop_item.last;

  always_comb begin
    sr_nxt   = sr_r;
    rr_nxt   = rr_r;
    pkt_nxt  = pkt_r;
    oct_nxt  = oct_r;
    frac_nxt = frac_r;
    lost_nxt = lost_r;
    hseq_nxt = hseq_r;
    jit_nxt  = jit_r;
    lsr_nxt  = lsr_r;
    dlsr_nxt = dlsr_r;
    hold_nxt = hold_r;
    peer_nxt = peer_r;
    unk_nxt  = unk_r;
    if (pop) begin
      unique case (pop_item.op)
        OP_NONE:      ;
        OP_SR_CNT:    sr_nxt   = sr_r + 32'd1;
        OP_RR_CNT:    rr_nxt   = rr_r + 32'd1;
        OP_UNKNOWN:   unk_nxt  = 1'b1;
        OP_SR_PKT:    pkt_nxt  = pop_item.word;
        OP_SR_OCT:    oct_nxt  = pop_item.word;
        OP_FRAC:      frac_nxt = pop_item.word[7:0];
        OP_LOST:      lost_nxt = pop_item.word[23:0];
        OP_HSEQ:      hseq_nxt = pop_item.word;
        OP_JIT:       jit_nxt  = pop_item.word;
        OP_LSR:       lsr_nxt  = pop_item.word;
        OP_DLSR:      dlsr_nxt = pop_item.word;
        OP_SSRC_HOLD: hold_nxt = pop_item.word;
        OP_CNAME:     peer_nxt = hold_r;
        default:      ;
      endcase
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sender_reports_seen   <= sr_nxt;
      out_receiver_reports_seen <= rr_nxt;
      out_sender_packet_total   <= pkt_nxt;
      out_sender_octet_total    <= oct_nxt;
      out_loss_fraction         <= frac_nxt;
      out_lost_total            <= lost_nxt;
      out_highest_sequence      <= hseq_nxt;
      out_arrival_jitter        <= jit_nxt;
      out_last_sr_stamp         <= lsr_nxt;
      out_delay_since_sr        <= dlsr_nxt;
      out_peer_ssrc             <= peer_nxt;
      out_unknown_type_seen     <= unk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || load) begin
      sr_r   <= '0;
      rr_r   <= '0;
      pkt_r  <= '0;
      oct_r  <= '0;
      frac_r <= '0;
      lost_r <= '0;
      hseq_r <= '0;
      jit_r  <= '0;
      lsr_r  <= '0;
      dlsr_r <= '0;
      hold_r <= '0;
      peer_r <= '0;
      unk_r  <= 1'b0;
    end else begin
      sr_r   <= sr_nxt;
      rr_r   <= rr_nxt;
      pkt_r  <= pkt_nxt;
      oct_r  <= oct_nxt;
      frac_r <= frac_nxt;
      lost_r <= lost_nxt;
      hseq_r <= hseq_nxt;
      jit_r  <= jit_nxt;
      lsr_r  <= lsr_nxt;
      dlsr_r <= dlsr_nxt;
      hold_r <= hold_nxt;
      peer_r <= peer_nxt;
      unk_r  <= unk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sim/rtcp_compound_report_parser_unit_test.sv */
`timescale 1ns / 1ps

module rtcp_compound_report_parser_unit_test;
  import rcrp_pkg::*;

  typedef struct packed {
    logic [31:0] sr_seen;
    logic [31:0] rr_seen;
    logic [31:0] pkt_total;
    logic [31:0] oct_total;
    logic [7:0]  frac;
    logic [23:0] lost;
    logic [31:0] hseq;
    logic [31:0] jitter;
    logic [31:0] lsr;
    logic [31:0] dlsr;
    logic [31:0] ssrc;
    logic        unknown;
  } snap_t;

  class snapshot_scoreboard;
    logic [OFS_W-1:0] ofs;
    logic [OFS_W-1:0] last_ofs;
    logic [7:0]       kind;
    logic [4:0]       blocks;
    logic [31:0]      shift_word;
    logic [31:0]      held_ssrc;
    logic             halted;
    snap_t            tally;
    snap_t            due_snapshots[$];
    int               errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ofs = '0;
      last_ofs = '0;
      kind = '0;
      blocks = '0;
      shift_word = '0;
      held_ssrc = '0;
      halted = 1'b0;
      tally = '0;
    endfunction

    function void take_block(logic [OFS_W-1:0] o, logic [OFS_W-1:0] base, logic [7:0] b);
      logic [OFS_W-1:0] rel;
      if (blocks == 5'd0 || o < base) return;
      rel = o - base;
      case (rel)
        BLK_FRAC: tally.frac = b;
        BLK_LOST: tally.lost = shift_word[23:0];
        BLK_HSEQ: tally.hseq = shift_word;
        BLK_JIT:  tally.jitter = shift_word;
        BLK_LSR:  tally.lsr = shift_word;
        BLK_DLSR: tally.dlsr = shift_word;
        default: ;
      endcase
    endfunction

    function void absorb_byte(logic [7:0] b);
      logic [OFS_W-1:0] o;
      o = ofs;
      shift_word = {shift_word[23:0], b};
      if (o == OFS_COUNT) begin
        blocks = b[4:0];
      end else if (o == OFS_KIND) begin
        kind = b;
        case (b)
          KIND_SR: tally.sr_seen = tally.sr_seen + 32'd1;
          KIND_RR: tally.rr_seen = tally.rr_seen + 32'd1;
          KIND_SDES, KIND_BYE, KIND_APP: ;
          default: begin
            halted = 1'b1;
            return;
          end
        endcase
      end else if (o == OFS_LEN_END) begin
        last_ofs = {shift_word[15:0], 2'b11};
      end else if (o > OFS_LEN_END) begin
        if (kind == KIND_SR) begin
          if (o == SR_PKT_END) tally.pkt_total = shift_word;
          else if (o == SR_OCT_END) tally.oct_total = shift_word;
          take_block(o, SR_BLOCK_OFS, b);
        end else if (kind == KIND_RR) begin
          take_block(o, RR_BLOCK_OFS, b);
        end else if (kind == KIND_SDES) begin
          if (o == SDES_SSRC_END) held_ssrc = shift_word;
          else if (o == SDES_ITEM_OFS && b == ITEM_CNAME) tally.ssrc = held_ssrc;
        end
      end
      if (o >= OFS_LEN_END && o >= last_ofs) ofs = '0;
      else ofs = o + 1'b1;
    endfunction

    function void note_byte(logic [7:0] b, logic eod);
      if (!halted) absorb_byte(b);
      if (eod) begin
        tally.unknown = halted;
        due_snapshots.push_back(tally);
        clear();
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_snapshot(snap_t got);
      snap_t want;
      if (due_snapshots.size() == 0) begin
        $display("%0t: snapshot expected none actual sr %0h rr %0h", $time,
                 got.sr_seen, got.rr_seen);
        errors++;
        return;
      end
      want = due_snapshots.pop_front();
      compare("sender_reports_seen", want.sr_seen, got.sr_seen);
      compare("receiver_reports_seen", want.rr_seen, got.rr_seen);
      compare("sender_packet_total", want.pkt_total, got.pkt_total);
      compare("sender_octet_total", want.oct_total, got.oct_total);
      compare("loss_fraction", 32'(want.frac), 32'(got.frac));
      compare("lost_total", 32'(want.lost), 32'(got.lost));
      compare("highest_sequence", want.hseq, got.hseq);
      compare("arrival_jitter", want.jitter, got.jitter);
      compare("last_sr_stamp", want.lsr, got.lsr);
      compare("delay_since_sr", want.dlsr, got.dlsr);
      compare("peer_ssrc", want.ssrc, got.ssrc);
      compare("unknown_type_seen", 32'(want.unknown), 32'(got.unknown));
    endfunction

    function void flag_leftovers();
      while (due_snapshots.size() != 0) begin
        $display("%0t: snapshot expected sr %0h rr %0h actual none", $time,
                 due_snapshots[0].sr_seen, due_snapshots[0].rr_seen);
        void'(due_snapshots.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_end_of_datagram;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_sender_reports_seen;
  logic [31:0] out_receiver_reports_seen;
  logic [31:0] out_sender_packet_total;
  logic [31:0] out_sender_octet_total;
  logic [7:0]  out_loss_fraction;
  logic [23:0] out_lost_total;
  logic [31:0] out_highest_sequence;
  logic [31:0] out_arrival_jitter;
  logic [31:0] out_last_sr_stamp;
  logic [31:0] out_delay_since_sr;
  logic [31:0] out_peer_ssrc;
  logic        out_unknown_type_seen;

  snapshot_scoreboard board;
  logic [7:0] dgram[$];
  int burst_left = 0;
  int bytes_sent = 0;
  int dgrams_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;

  rtcp_compound_report_parser_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_end_of_datagram(in_end_of_datagram),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sender_reports_seen(out_sender_reports_seen),
    .out_receiver_reports_seen(out_receiver_reports_seen),
    .out_sender_packet_total(out_sender_packet_total),
    .out_sender_octet_total(out_sender_octet_total),
    .out_loss_fraction(out_loss_fraction),
    .out_lost_total(out_lost_total),
    .out_highest_sequence(out_highest_sequence),
    .out_arrival_jitter(out_arrival_jitter),
    .out_last_sr_stamp(out_last_sr_stamp),
    .out_delay_since_sr(out_delay_since_sr),
    .out_peer_ssrc(out_peer_ssrc),
    .out_unknown_type_seen(out_unknown_type_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 120);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_left % 40) < 25;
    endcase
  end

  // sample at the falling edge, score at the following rising edge
  always begin
    snap_t got;
    bit fire;
    @(negedge clk);
    fire = (out_valid === 1'b1) && (out_stall === 1'b0);
    got = {out_sender_reports_seen, out_receiver_reports_seen,
           out_sender_packet_total, out_sender_octet_total, out_loss_fraction,
           out_lost_total, out_highest_sequence, out_arrival_jitter,
           out_last_sr_stamp, out_delay_since_sr, out_peer_ssrc,
           out_unknown_type_seen};
    @(posedge clk);
    if (fire) board.check_snapshot(got);
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_datagram <= eod;
    do begin
      @(negedge clk);
      took = (in_stall === 1'b0);
      @(posedge clk);
    end while (!took);
    board.note_byte(b, eod);
  endtask

  task automatic send_datagram();
    int i;
    for (i = 0; i < dgram.size(); i++)
      send_byte(dgram[i], i == dgram.size() - 1);
    bytes_sent += dgram.size();
    dgrams_sent++;
  endtask

  // hold off until every snapshot has been taken or the wait limit runs out
  task automatic drain(input int max_cycles);
    int n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (board.due_snapshots.size() != 0 && n < max_cycles);
  endtask

  task automatic add_packet(input logic [7:0] kind, input int words);
    logic [15:0] len;
    logic [7:0] b;
    int i;
    len = 16'(words - 1);
    b = 8'($urandom);
    b[4:0] = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd1;
    dgram.push_back(b);
    dgram.push_back(kind);
    dgram.push_back(len[15:8]);
    dgram.push_back(len[7:0]);
    for (i = 4; i < words * 4; i++) begin
      b = 8'($urandom);
      if (kind == KIND_SDES && i == 8 && $urandom_range(0, 3) != 0) b = ITEM_CNAME;
      dgram.push_back(b);
    end
  endtask

  task automatic build_random_datagram();
    int style;
    int npk;
    int k;
    int words;
    int cut;
    logic [7:0] kind;
    dgram.delete();
    style = $urandom_range(0, 19);
    if (style == 0) begin
      repeat ($urandom_range(1, 24)) dgram.push_back(8'($urandom));
    end else begin
      npk = $urandom_range(1, 3);
      for (k = 0; k < npk; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            kind = KIND_SR;
            words = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 13;
          end
          3, 4, 5: begin
            kind = KIND_RR;
            words = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 8;
          end
          6, 7: begin
            kind = KIND_SDES;
            words = $urandom_range(1, 5);
          end
          8: begin
            kind = KIND_BYE;
            words = $urandom_range(1, 3);
          end
          default: begin
            kind = KIND_APP;
            words = $urandom_range(2, 4);
          end
        endcase
        if (style == 1 && k == npk - 1) kind = 8'($urandom);
        add_packet(kind, words);
      end
      if (style == 2) begin
        cut = $urandom_range(1, dgram.size());
        dgram = dgram[0:cut-1];
      end
      if (style == 3) begin
        dgram[2] = 8'($urandom);
        dgram[3] = 8'($urandom);
      end
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_end_of_datagram <= 1'b0;
    rst_n <= 1'b0;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte datagram
    dgram = '{8'hFF};
    send_datagram();
    // unknown type, trailing bytes ignored
    dgram = '{8'h00, 8'hFF, 8'h12, 8'h34};
    send_datagram();
    // APP, BYE, then SDES led by CNAME cut off after the item type
    dgram = '{8'h80, KIND_APP, 8'h00, 8'h00,
              8'hA1, KIND_BYE, 8'h00, 8'h00,
              8'h81, KIND_SDES, 8'h00, 8'h02, 8'hDE, 8'hAD, 8'hBE, 8'hEF, ITEM_CNAME};
    send_datagram();
    drain(20000);

    while (bytes_sent < 1500 || dgrams_sent < 48) begin
      build_random_datagram();
      send_datagram();
      if ($urandom_range(0, 9) == 0) drain(20000);
    end

    drain(100000);
    repeat (10) @(posedge clk);
    board.flag_leftovers();
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rcrp_pkg.sv
src/rcrp_front.sv
src/rcrp_queue.sv
src/rcrp_back.sv
src/rtcp_compound_report_parser_unit.sv
sim/rtcp_compound_report_parser_unit_test.sv
